[design/free_range_allocator_core_macros.svh]
// Assertion macros for the free range allocator core.
`ifndef FREE_RANGE_ALLOCATOR_CORE_MACROS_SVH
`define FREE_RANGE_ALLOCATOR_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define FRAC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FRAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FRAC_ASSERT(lbl, clk, rst_n, prop, msg)
`define FRAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[design/frac_pkg.sv]
// Types, constants and codes shared by the free range allocator core.
package frac_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int ADDRESS_BITS  = 16;

    localparam int OP_W    = 2;
    localparam int BASE_W  = 16;
    localparam int LEN_W   = 16;
    localparam int STAT_W  = 3;
    localparam int SUM_W   = BASE_W + 1;
    localparam int START_W = ADDRESS_BITS;
    localparam int END_W   = ADDRESS_BITS + 1;
    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);

    localparam logic [SUM_W-1:0] ADDR_LIMIT = SUM_W'(1) << ADDRESS_BITS;

    typedef enum logic [OP_W-1:0] {
        OP_FREE     = 2'd0,
        OP_ALLOC_AT = 2'd1,
        OP_BEST_FIT = 2'd2,
        OP_UNUSED   = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_NOFIT   = 3'd1,
        ST_NOTFREE = 3'd2,
        ST_FULL    = 3'd3,
        ST_RANGE   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        TC_NONE,
        TC_WRITE,
        TC_INSERT,
        TC_REMOVE
    } t_tc_op;

    typedef struct packed {
        t_tc_op               op;
        logic [IDX_W-1:0]     idx;
        logic [START_W-1:0]   start;
        logic [END_W-1:0]     stop;
    } t_tcmd;

    typedef struct packed {
        logic                 valid;
        t_status              status;
        logic [BASE_W-1:0]    granted;
    } t_done;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MERGE_DEL,
        S_SPLIT_WR,
        S_DONE
    } t_state;

endpackage

[design/frac_if.sv]
// Request and response channel interfaces of the free range allocator core.
interface frac_req_if;
    import frac_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [BASE_W-1:0] range_base;
    logic [LEN_W-1:0]  range_length;

    modport source (output valid, operation, range_base, range_length, input ready);
    modport sink   (input valid, operation, range_base, range_length, output ready);
endinterface

interface frac_rsp_if;
    import frac_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [BASE_W-1:0] granted_base;

    modport source (output valid, status, granted_base, input ready);
    modport sink   (input valid, status, granted_base, output ready);
endinterface

[design/frac_table.sv]
// Sorted free range table with entry write, insert and remove.
module frac_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  frac_pkg::t_tcmd               i_tcmd,
    input  logic [frac_pkg::IDX_W-1:0]    i_rd_idx,
    output logic [frac_pkg::START_W-1:0]  o_rd_start,
    output logic [frac_pkg::END_W-1:0]    o_rd_end,
    output logic [frac_pkg::CNT_W-1:0]    o_used
);
    import frac_pkg::*;

    logic [START_W-1:0] r_start [TABLE_ENTRIES];
    logic [END_W-1:0]   r_end   [TABLE_ENTRIES];
    logic [CNT_W-1:0]   r_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            case (i_tcmd.op)
                TC_INSERT: r_used <= r_used + CNT_W'(1);
                TC_REMOVE: r_used <= r_used - CNT_W'(1);
                default:   r_used <= r_used;
            endcase
        end
    end

    for (genvar j = 0; j < TABLE_ENTRIES; j++) begin : g_entry
        always_ff @(posedge i_clk) begin
            case (i_tcmd.op)
                TC_WRITE: begin
                    if (i_tcmd.idx == IDX_W'(j)) begin
                        r_start[j] <= i_tcmd.start;
                        r_end[j]   <= i_tcmd.stop;
                    end
                end
                TC_INSERT: begin
                    if (i_tcmd.idx == IDX_W'(j)) begin
                        r_start[j] <= i_tcmd.start;
                        r_end[j]   <= i_tcmd.stop;
                    end else if (j > 0 && i_tcmd.idx < IDX_W'(j)) begin
                        r_start[j] <= r_start[(j > 0) ? j - 1 : 0];
                        r_end[j]   <= r_end[(j > 0) ? j - 1 : 0];
                    end
                end
                TC_REMOVE: begin
                    if (j < TABLE_ENTRIES - 1 && i_tcmd.idx <= IDX_W'(j)) begin
                        r_start[j] <= r_start[(j < TABLE_ENTRIES - 1) ? j + 1 : j];
                        r_end[j]   <= r_end[(j < TABLE_ENTRIES - 1) ? j + 1 : j];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_rd_start = r_start[i_rd_idx];
    assign o_rd_end   = r_end[i_rd_idx];
    assign o_used     = r_used;

endmodule

[design/frac_ctrl.sv]
// Request sequencer with the shared per-entry compare unit.
module frac_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  logic [frac_pkg::OP_W-1:0]     i_req_op,
    input  logic [frac_pkg::BASE_W-1:0]   i_req_base,
    input  logic [frac_pkg::LEN_W-1:0]    i_req_len,
    output logic                          o_req_ready,
    input  logic [frac_pkg::CNT_W-1:0]    i_used,
    output logic [frac_pkg::IDX_W-1:0]    o_rd_idx,
    input  logic [frac_pkg::START_W-1:0]  i_rd_start,
    input  logic [frac_pkg::END_W-1:0]    i_rd_end,
    output frac_pkg::t_tcmd               o_tcmd,
    input  logic                          i_slot_free,
    output frac_pkg::t_done               o_done
);
    import frac_pkg::*;

    t_state              r_state, n_state;
    t_op                 r_op, n_op;
    logic [BASE_W-1:0]   r_s, n_s;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [END_W-1:0]    r_e, n_e;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [CNT_W-1:0]    r_pos, n_pos;
    logic [IDX_W-1:0]    r_first, n_first;
    logic [START_W-1:0]  r_ms, n_ms;
    logic [END_W-1:0]    r_me, n_me;
    logic                r_found, n_found;
    logic [IDX_W-1:0]    r_best_idx, n_best_idx;
    logic [START_W-1:0]  r_best_start, n_best_start;
    logic [END_W-1:0]    r_best_end, n_best_end;
    logic [END_W-1:0]    r_best_size, n_best_size;
    t_status             r_status, n_status;
    logic [BASE_W-1:0]   r_granted, n_granted;

    logic [SUM_W-1:0]    w_sum;
    logic [END_W-1:0]    w_st_ext;
    logic [END_W-1:0]    w_s_ext;
    logic [END_W-1:0]    w_len_ext;
    logic [END_W-1:0]    w_sz;
    logic [END_W-1:0]    w_bf_start;
    logic                w_in_scan;
    logic                w_full;
    logic [IDX_W-1:0]    w_idx;

    assign w_sum      = SUM_W'(i_req_base) + SUM_W'(i_req_len);
    assign w_idx      = r_idx[IDX_W-1:0];
    assign w_st_ext   = END_W'(i_rd_start);
    assign w_s_ext    = END_W'(r_s);
    assign w_len_ext  = END_W'(r_len);
    assign w_sz       = i_rd_end - w_st_ext;
    assign w_bf_start = END_W'(r_best_start) + w_len_ext;
    assign w_in_scan  = r_idx < i_used;
    assign w_full     = i_used >= CNT_W'(TABLE_ENTRIES);
    assign o_rd_idx   = w_idx;
    assign o_req_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_s          <= n_s;
        r_len        <= n_len;
        r_e          <= n_e;
        r_idx        <= n_idx;
        r_cnt        <= n_cnt;
        r_pos        <= n_pos;
        r_first      <= n_first;
        r_ms         <= n_ms;
        r_me         <= n_me;
        r_found      <= n_found;
        r_best_idx   <= n_best_idx;
        r_best_start <= n_best_start;
        r_best_end   <= n_best_end;
        r_best_size  <= n_best_size;
        r_status     <= n_status;
        r_granted    <= n_granted;
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_s          = r_s;
        n_len        = r_len;
        n_e          = r_e;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_pos        = r_pos;
        n_first      = r_first;
        n_ms         = r_ms;
        n_me         = r_me;
        n_found      = r_found;
        n_best_idx   = r_best_idx;
        n_best_start = r_best_start;
        n_best_end   = r_best_end;
        n_best_size  = r_best_size;
        n_status     = r_status;
        n_granted    = r_granted;
        o_tcmd       = '{op: TC_NONE, idx: '0, start: '0, stop: '0};
        o_done       = '{valid: 1'b0, status: r_status, granted: r_granted};

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_op      = t_op'(i_req_op);
                    n_s       = i_req_base;
                    n_len     = i_req_len;
                    n_e       = END_W'(w_sum);
                    n_idx     = '0;
                    n_cnt     = '0;
                    n_pos     = '0;
                    n_found   = 1'b0;
                    n_ms      = START_W'(i_req_base);
                    n_me      = END_W'(w_sum);
                    n_status  = ST_OK;
                    n_granted = '0;
                    case (t_op'(i_req_op))
                        OP_FREE, OP_ALLOC_AT: begin
                            if (w_sum > ADDR_LIMIT) begin
                                n_status = ST_RANGE;
                                n_state  = S_DONE;
                            end else if (i_req_len == '0) begin
                                n_granted = i_req_base;
                                n_state   = S_DONE;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_BEST_FIT: begin
                            n_state = (i_req_len == '0) ? S_DONE : S_SCAN;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (w_in_scan) begin
                    n_idx = r_idx + CNT_W'(1);
                    case (r_op)
                        OP_FREE: begin
                            if (w_st_ext <= r_e && i_rd_end >= w_s_ext) begin
                                if (r_cnt == '0) begin
                                    n_first = w_idx;
                                end
                                n_cnt = r_cnt + CNT_W'(1);
                                if (i_rd_start < r_ms) begin
                                    n_ms = i_rd_start;
                                end
                                if (i_rd_end > r_me) begin
                                    n_me = i_rd_end;
                                end
                            end
                            if (w_st_ext < w_s_ext) begin
                                n_pos = r_pos + CNT_W'(1);
                            end
                        end
                        OP_ALLOC_AT: begin
                            if (w_st_ext <= w_s_ext && i_rd_end >= r_e) begin
                                n_state   = S_DONE;
                                n_granted = r_s;
                                if (w_st_ext == w_s_ext && i_rd_end == r_e) begin
                                    o_tcmd.op  = TC_REMOVE;
                                    o_tcmd.idx = w_idx;
                                end else if (w_st_ext == w_s_ext) begin
                                    o_tcmd = '{op: TC_WRITE, idx: w_idx,
                                               start: START_W'(r_e), stop: i_rd_end};
                                end else if (i_rd_end == r_e) begin
                                    o_tcmd = '{op: TC_WRITE, idx: w_idx,
                                               start: i_rd_start, stop: w_s_ext};
                                end else if (w_full) begin
                                    n_status  = ST_FULL;
                                    n_granted = '0;
                                end else begin
                                    o_tcmd = '{op: TC_INSERT, idx: w_idx + IDX_W'(1),
                                               start: START_W'(r_e), stop: i_rd_end};
                                    n_first = w_idx;
                                    n_ms    = i_rd_start;
                                    n_state = S_SPLIT_WR;
                                end
                            end
                        end
                        default: begin
                            if (w_sz >= w_len_ext && (!r_found || w_sz < r_best_size)) begin
                                n_found      = 1'b1;
                                n_best_idx   = w_idx;
                                n_best_start = i_rd_start;
                                n_best_end   = i_rd_end;
                                n_best_size  = w_sz;
                            end
                        end
                    endcase
                end else begin
                    n_state = S_DONE;
                    case (r_op)
                        OP_FREE: begin
                            if (r_cnt == '0) begin
                                if (w_full) begin
                                    n_status = ST_FULL;
                                end else begin
                                    o_tcmd = '{op: TC_INSERT, idx: r_pos[IDX_W-1:0],
                                               start: START_W'(r_s), stop: r_e};
                                    n_granted = r_s;
                                end
                            end else begin
                                o_tcmd = '{op: TC_WRITE, idx: r_first,
                                           start: r_ms, stop: r_me};
                                n_granted = r_s;
                                n_state   = S_MERGE_DEL;
                            end
                        end
                        OP_ALLOC_AT: begin
                            n_status = ST_NOTFREE;
                        end
                        default: begin
                            if (!r_found) begin
                                n_status = ST_NOFIT;
                            end else begin
                                n_granted = BASE_W'(r_best_start);
                                if (r_best_size == w_len_ext) begin
                                    o_tcmd.op  = TC_REMOVE;
                                    o_tcmd.idx = r_best_idx;
                                end else begin
                                    o_tcmd = '{op: TC_WRITE, idx: r_best_idx,
                                               start: START_W'(w_bf_start),
                                               stop: r_best_end};
                                end
                            end
                        end
                    endcase
                end
            end

            S_MERGE_DEL: begin
                if (r_cnt > CNT_W'(1)) begin
                    o_tcmd.op  = TC_REMOVE;
                    o_tcmd.idx = r_first + IDX_W'(1);
                    n_cnt      = r_cnt - CNT_W'(1);
                end else begin
                    n_state = S_DONE;
                end
            end

            S_SPLIT_WR: begin
                o_tcmd  = '{op: TC_WRITE, idx: r_first, start: r_ms, stop: w_s_ext};
                n_state = S_DONE;
            end

            S_DONE: begin
                if (i_slot_free) begin
                    o_done.valid = 1'b1;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[design/free_range_allocator_core.sv]
// Top level of the free range allocator: sequencer, range table, response register.
//
//  channel  dir  modport  payload
//  i_req    in   sink     operation[1:0], range_base[15:0], range_length[15:0]
//  o_rsp    out  source   status[2:0], granted_base[15:0]
//
// A full scan reads each used entry from accept to response; an allocate-at stops at the
// entry that holds it, a split adds a write in S_SPLIT_WR and a free adds removals in
// S_MERGE_DEL for merged ranges. The scan reads one table entry per cycle through the
// shared compare unit. Early exits (zero length, out of range, unused code) skip S_SCAN.
// Synchronous reset empties the table at once; no clearing pass.
// A stalled response holds in the output register while the next request is accepted.
module free_range_allocator_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    frac_req_if.sink   i_req,
    frac_rsp_if.source o_rsp
);
    import frac_pkg::*;

    `include "free_range_allocator_core_macros.svh"

    t_tcmd                w_tcmd;
    t_done                w_done;
    logic [IDX_W-1:0]     w_rd_idx;
    logic [START_W-1:0]   w_rd_start;
    logic [END_W-1:0]     w_rd_end;
    logic [CNT_W-1:0]     w_used;
    logic                 w_slot_free;

    logic                 r_out_valid;
    logic [STAT_W-1:0]    r_out_status;
    logic [BASE_W-1:0]    r_out_granted;

    frac_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_op    (i_req.operation),
        .i_req_base  (i_req.range_base),
        .i_req_len   (i_req.range_length),
        .o_req_ready (i_req.ready),
        .i_used      (w_used),
        .o_rd_idx    (w_rd_idx),
        .i_rd_start  (w_rd_start),
        .i_rd_end    (w_rd_end),
        .o_tcmd      (w_tcmd),
        .i_slot_free (w_slot_free),
        .o_done      (w_done)
    );

    frac_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tcmd     (w_tcmd),
        .i_rd_idx   (w_rd_idx),
        .o_rd_start (w_rd_start),
        .o_rd_end   (w_rd_end),
        .o_used     (w_used)
    );

    assign w_slot_free = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done.valid) begin
            r_out_status  <= w_done.status;
            r_out_granted <= w_done.granted;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.granted_base = r_out_granted;

    `FRAC_ASSERT(a_used_bound, i_clk, i_rst_n, w_used <= CNT_W'(TABLE_ENTRIES), "table count overflow")
    `FRAC_ASSERT(a_done_slot, i_clk, i_rst_n, !w_done.valid || w_slot_free, "response overwritten")
    `FRAC_ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_req.valid && i_req.ready, !i_req.ready, "ready while busy")
    `FRAC_ASSERT_NEXT(a_done_out, i_clk, i_rst_n, w_done.valid, o_rsp.valid, "response lost")

endmodule

[tb/frac_range_checker.sv]
// Response checker: mirrors the free range table and compares every allocator response.
`timescale 1ns / 100ps
module frac_range_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    frac_req_if  i_req,
    frac_rsp_if  i_rsp,
    output int   o_mismatches,
    output int   o_pending,
    output int   o_checked
);
    import frac_pkg::*;

    typedef struct packed {
        t_status           status;
        logic [BASE_W-1:0] granted;
    } t_grant;

    logic [START_W-1:0] span_lo [TABLE_ENTRIES];
    logic [END_W-1:0]   span_hi [TABLE_ENTRIES];
    int                 span_count = 0;
    t_grant             grant_q [$];
    int                 mismatches = 0;
    int                 checked = 0;

    function automatic void drop_span(int pos);
        int i;
        for (i = pos; i + 1 < span_count; i++) begin
            span_lo[i] = span_lo[i + 1];
            span_hi[i] = span_hi[i + 1];
        end
        span_count--;
    endfunction

    function automatic void put_span(int pos, logic [START_W-1:0] lo, logic [END_W-1:0] hi);
        int i;
        for (i = span_count; i > pos; i--) begin
            span_lo[i] = span_lo[i - 1];
            span_hi[i] = span_hi[i - 1];
        end
        span_lo[pos] = lo;
        span_hi[pos] = hi;
        span_count++;
    endfunction

    function automatic t_status merge_span(logic [START_W-1:0] s, logic [END_W-1:0] e);
        int                 first;
        int                 hits;
        int                 i;
        logic [START_W-1:0] ms;
        logic [END_W-1:0]   me;
        first = span_count;
        hits  = 0;
        ms    = s;
        me    = e;
        for (i = 0; i < span_count; i++) begin
            if (span_lo[i] <= e && span_hi[i] >= s) begin
                if (hits == 0) begin
                    first = i;
                end
                hits++;
                if (span_lo[i] < ms) begin
                    ms = span_lo[i];
                end
                if (span_hi[i] > me) begin
                    me = span_hi[i];
                end
            end
        end
        if (hits == 0) begin
            if (span_count >= TABLE_ENTRIES) begin
                return ST_FULL;
            end
            first = 0;
            while (first < span_count && span_lo[first] < s) begin
                first++;
            end
            put_span(first, s, e);
            return ST_OK;
        end
        span_lo[first] = ms;
        span_hi[first] = me;
        for (i = 1; i < hits; i++) begin
            drop_span(first + 1);
        end
        return ST_OK;
    endfunction

    function automatic t_status carve_span(logic [START_W-1:0] s, logic [END_W-1:0] e);
        int i;
        for (i = 0; i < span_count; i++) begin
            if (span_lo[i] <= s && span_hi[i] >= e) begin
                if (span_lo[i] == s && span_hi[i] == e) begin
                    drop_span(i);
                end else if (span_lo[i] == s) begin
                    span_lo[i] = e[START_W-1:0];
                end else if (span_hi[i] == e) begin
                    span_hi[i] = END_W'(s);
                end else begin
                    if (span_count >= TABLE_ENTRIES) begin
                        return ST_FULL;
                    end
                    put_span(i + 1, e[START_W-1:0], span_hi[i]);
                    span_hi[i] = END_W'(s);
                end
                return ST_OK;
            end
        end
        return ST_NOTFREE;
    endfunction

    function automatic t_status fit_span(logic [LEN_W-1:0] len, output logic [BASE_W-1:0] base);
        int               best;
        int               i;
        bit               found;
        logic [END_W-1:0] size;
        logic [END_W-1:0] best_size;
        logic [END_W-1:0] bumped;
        best      = 0;
        found     = 1'b0;
        best_size = '0;
        base      = '0;
        for (i = 0; i < span_count; i++) begin
            size = span_hi[i] - END_W'(span_lo[i]);
            if (size >= END_W'(len) && (!found || size < best_size)) begin
                found     = 1'b1;
                best      = i;
                best_size = size;
            end
        end
        if (!found) begin
            return ST_NOFIT;
        end
        base   = span_lo[best];
        bumped = END_W'(span_lo[best]) + END_W'(len);
        if (bumped == span_hi[best]) begin
            drop_span(best);
        end else begin
            span_lo[best] = bumped[START_W-1:0];
        end
        return ST_OK;
    endfunction

    function automatic t_grant predict_grant(t_op op, logic [BASE_W-1:0] base,
                                             logic [LEN_W-1:0] len);
        t_grant            g;
        logic [SUM_W-1:0]  stop;
        logic [BASE_W-1:0] fit_base;
        g.status = ST_OK;
        g.granted = '0;
        stop = SUM_W'(base) + SUM_W'(len);
        case (op)
            OP_FREE, OP_ALLOC_AT: begin
                if (stop > ADDR_LIMIT) begin
                    g.status = ST_RANGE;
                end else if (len == '0) begin
                    g.granted = base;
                end else begin
                    g.status = (op == OP_FREE) ? merge_span(base, stop) : carve_span(base, stop);
                    if (g.status == ST_OK) begin
                        g.granted = base;
                    end
                end
            end
            OP_BEST_FIT: begin
                if (len != '0) begin
                    g.status = fit_span(len, fit_base);
                    if (g.status == ST_OK) begin
                        g.granted = fit_base;
                    end
                end
            end
            default: begin
            end
        endcase
        return g;
    endfunction

    always @(posedge i_clk) begin : watch
        t_grant want;
        if (!i_rst_n) begin
            span_count = 0;
            grant_q.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (grant_q.size() == 0) begin
                    $display("%0t: unexpected response, status %0d base 0x%04h",
                             $time, i_rsp.status, i_rsp.granted_base);
                    mismatches++;
                end else begin
                    want = grant_q.pop_front();
                    checked++;
                    if (i_rsp.status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, want.status, i_rsp.status);
                        mismatches++;
                    end
                    if (i_rsp.granted_base !== want.granted) begin
                        $display("%0t: granted_base mismatch, expected 0x%04h actual 0x%04h",
                                 $time, want.granted, i_rsp.granted_base);
                        mismatches++;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                grant_q.push_back(predict_grant(t_op'(i_req.operation), i_req.range_base,
                                                i_req.range_length));
            end
        end
        o_mismatches <= mismatches;
        o_pending    <= grant_q.size();
        o_checked    <= checked;
    end

endmodule

[tb/free_range_allocator_core_tb.sv]
// Testbench top: drives requests and response back-pressure around the allocator core.
`timescale 1ns / 100ps
module free_range_allocator_core_tb;
    import frac_pkg::*;

    localparam int RESET_CYCLES = 12;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam int WINDOW_SPAN  = 2048;
    localparam int POOL_DEPTH   = 32;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              hold_rsp = 1'b0;
    int                recv_idle_pct = 0;
    int                send_idle_pct = 0;
    int                stall_cycles = 0;
    int                items_sent = 0;
    int                mismatches;
    int                pending;
    int                checked;
    logic [BASE_W-1:0] win_lo = '0;
    logic [31:0]       freed_q [$];
    logic [31:0]       taken_q [$];

    frac_req_if req_if ();
    frac_rsp_if rsp_if ();

    free_range_allocator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    frac_range_checker range_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        @(posedge i_clk);
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_request(input t_op op, input logic [BASE_W-1:0] base,
                                input logic [LEN_W-1:0] len);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.operation    <= op;
        req_if.range_base   <= base;
        req_if.range_length <= len;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_random();
        t_op               op;
        logic [BASE_W-1:0] base;
        logic [LEN_W-1:0]  len;
        logic [31:0]       pick;
        int                roll;
        int                off;
        roll = $urandom_range(99);
        op   = OP_FREE;
        base = win_lo + BASE_W'($urandom_range(WINDOW_SPAN - 1));
        len  = LEN_W'($urandom_range(64, 1));
        if (roll < 30) begin
            op = OP_FREE;
        end else if (roll < 42 && taken_q.size() != 0) begin
            pick = taken_q[$urandom_range(taken_q.size() - 1)];
            base = pick[31:16];
            len  = pick[15:0];
        end else if (roll < 65) begin
            op = OP_ALLOC_AT;
            if (freed_q.size() != 0 && $urandom_range(3) != 0) begin
                pick = freed_q[$urandom_range(freed_q.size() - 1)];
                off  = $urandom_range(pick[15:0] - 1);
                base = pick[31:16] + BASE_W'(off);
                len  = LEN_W'($urandom_range(pick[15:0] - off, 1));
            end
        end else if (roll < 90) begin
            op   = OP_BEST_FIT;
            base = BASE_W'($urandom);
            len  = LEN_W'($urandom_range(48, 1));
        end else if (roll < 94) begin
            op   = t_op'($urandom_range(2));
            base = BASE_W'($urandom);
            len  = LEN_W'($urandom_range(65535, 1));
        end else if (roll < 97) begin
            op   = t_op'($urandom_range(2));
            base = BASE_W'($urandom);
            len  = '0;
        end else if (roll < 98) begin
            op   = OP_UNUSED;
            base = BASE_W'($urandom);
            len  = LEN_W'($urandom);
        end else begin
            op   = t_op'($urandom_range(1));
            base = 16'hFFFF - BASE_W'($urandom_range(63));
            len  = LEN_W'($urandom_range(128, 1));
        end
        if (len != '0 && ({1'b0, base} + SUM_W'(len)) <= ADDR_LIMIT) begin
            if (op == OP_FREE) begin
                freed_q.push_back({base, len});
                if (freed_q.size() > POOL_DEPTH) void'(freed_q.pop_front());
            end else if (op == OP_ALLOC_AT) begin
                taken_q.push_back({base, len});
                if (taken_q.size() > POOL_DEPTH) void'(taken_q.pop_front());
            end
        end
        send_request(op, base, len);
    endtask

    task automatic run_random(input int count, input bit with_hold);
        int n;
        for (n = 0; n < count; n++) begin
            if (n % 150 == 0) begin
                win_lo = {4'($urandom_range(15)), 12'h000};
            end
            if (with_hold && n == 100) begin
                fork
                    begin
                        hold_rsp <= 1'b1;
                        repeat (HOLD_CYCLES) @(posedge i_clk);
                        hold_rsp <= 1'b0;
                    end
                join_none
            end
            send_random();
        end
    endtask

    initial begin
        req_if.valid        = 1'b0;
        req_if.operation    = OP_FREE;
        req_if.range_base   = '0;
        req_if.range_length = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n       <= 1'b1;
        send_idle_pct  = 21;
        recv_idle_pct <= 56;

        send_request(OP_BEST_FIT, 16'd0,     16'd1);
        send_request(OP_ALLOC_AT, 16'h1234,  16'd16);
        send_request(OP_FREE,     16'd0,     16'hFFFF);
        send_request(OP_FREE,     16'hFFFF,  16'd1);
        send_request(OP_FREE,     16'hFFFF,  16'd2);
        send_request(OP_ALLOC_AT, 16'hFFFF,  16'd1);
        send_request(OP_ALLOC_AT, 16'd1,     16'hFFFE);
        send_request(OP_FREE,     16'h0100,  16'd0);
        send_request(OP_BEST_FIT, 16'hFFFF,  16'd0);
        send_request(OP_ALLOC_AT, 16'd0,     16'd0);
        send_request(OP_UNUSED,   16'hFFFF,  16'hFFFF);
        send_request(OP_UNUSED,   16'd0,     16'd0);
        send_request(OP_ALLOC_AT, 16'd0,     16'd1);
        send_request(OP_FREE,     16'd1000,  16'd10);
        send_request(OP_FREE,     16'd2000,  16'd20);
        send_request(OP_FREE,     16'd3000,  16'd10);
        send_request(OP_BEST_FIT, 16'd0,     16'd10);
        send_request(OP_FREE,     16'd1010,  16'd990);
        send_request(OP_FREE,     16'd1500,  16'd1600);
        send_request(OP_ALLOC_AT, 16'd2000,  16'd10);
        send_request(OP_FREE,     16'd1600,  16'd5);
        send_request(OP_ALLOC_AT, 16'd2005,  16'd10);
        send_request(OP_BEST_FIT, 16'd0,     16'hFFFF);
        send_request(OP_ALLOC_AT, 16'hFFFF,  16'hFFFF);
        send_request(OP_FREE,     16'h8000,  16'h8000);

        run_random(420, 1'b1);
        send_idle_pct  = 56;
        recv_idle_pct <= 21;
        run_random(420, 1'b0);
        send_idle_pct  = 0;
        recv_idle_pct <= 0;
        run_random(410, 1'b0);

        req_if.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests: directed corners, two lopsided idle mixes, no idling,",
                 items_sent);
        $display("and a %0d-cycle response hold-off; %0d responses checked, %0d mismatches.",
                 HOLD_CYCLES, checked, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/frac_pkg.sv
design/frac_if.sv
design/frac_table.sv
design/frac_ctrl.sv
design/free_range_allocator_core.sv
tb/frac_range_checker.sv
tb/free_range_allocator_core_tb.sv
